>>> hdl/ffza_pkg.sv
package ffza_pkg;

    localparam int MAX_BLOCKS  = 32;
    localparam int OFFSET_BITS = 16;
    localparam int CHUNK_BYTES = 8;

    localparam int OP_W   = 2;
    localparam int OFF_W  = OFFSET_BITS;
    localparam int SIZE_W = OFFSET_BITS + 1;
    localparam int STAT_W = 3;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    localparam logic [SIZE_W-1:0] ZONE_LIMIT     = SIZE_W'(64'd1 << OFFSET_BITS);
    localparam logic [SIZE_W-1:0] RESET_ZONE_REQ = SIZE_W'(4096);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NOSPACE  = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_BADARG   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // Round the requested size up to a whole chunk, then clip to the offset space.
    function automatic logic [SIZE_W-1:0] zone_bytes(input logic [SIZE_W-1:0] req);
        logic [SIZE_W:0] up;
        up = {1'b0, req} + (SIZE_W+1)'(CHUNK_BYTES - 1);
        up = up & ~((SIZE_W+1)'(CHUNK_BYTES - 1));
        if (up > {1'b0, ZONE_LIMIT}) begin
            return ZONE_LIMIT;
        end
        return up[SIZE_W-1:0];
    endfunction

endpackage

>>> hdl/ffza_if.sv
interface ffza_req_if;
    import ffza_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] req_size;
    logic [OFF_W-1:0]  offset;
    modport source (output valid, op, req_size, offset, input ready);
    modport sink   (input valid, op, req_size, offset, output ready);
endinterface

interface ffza_res_if;
    import ffza_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  alloc_offset;
    logic [SIZE_W-1:0] found_size;
    logic [SIZE_W-1:0] avail_bytes;
    logic [CNT_W-1:0]  block_count;
    modport source (output valid, status, alloc_offset, found_size, avail_bytes, block_count,
                    input ready);
    modport sink   (input valid, status, alloc_offset, found_size, avail_bytes, block_count,
                    output ready);
endinterface

interface ffza_cfg_if;
    import ffza_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hdl/first_fit_zone_allocator_unit.sv
// Channel   Dir  Payload                                                    Transfer
// i_cfg     in   data (zone size request)                                   valid & ready
// i_req     in   op, req_size, offset                                       valid & ready
// o_res     out  status, alloc_offset, found_size, avail_bytes, block_count valid & ready
//
// One request at a time: ready is high only in idle, so a new request is taken only
// after the previous one has returned to idle. A rejected request goes from idle
// straight to the emit state; a placed allocate scans, shifts the upper entries up,
// puts the entry and emits, and a free scans, shifts the upper entries down and emits.
// The entry table is one memory with one read and one write port.
// Synchronous active-low reset clears the block count and used bytes and loads the
// zone register with 4096. A result waits in the output register; a held result
// stalls only the final step.
module first_fit_zone_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffza_cfg_if.sink    i_cfg,
    ffza_req_if.sink    i_req,
    ffza_res_if.source  o_res
);
    import ffza_pkg::*;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_zone_req;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [SIZE_W-1:0] r_used, n_used;
    logic [OP_W-1:0]   r_op, n_op;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SIZE_W-1:0] r_pos, n_pos;
    t_status           r_status, n_status;
    logic [OFF_W-1:0]  r_placed, n_placed;
    logic [SIZE_W-1:0] r_found, n_found;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [OFF_W-1:0]  r_out_offset;
    logic [SIZE_W-1:0] r_out_found;
    logic [SIZE_W-1:0] r_out_free;
    logic [CNT_W-1:0]  r_out_count;

    t_entry            mem [MAX_BLOCKS];
    t_entry            r_rd_data;
    logic [IDX_W-1:0]  w_rd_addr;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_entry            w_wr_data;

    logic              w_in_fire;
    logic              w_emit;
    logic [SIZE_W-1:0] w_zone;
    logic [SIZE_W-1:0] w_free;
    logic [SIZE_W-1:0] w_s;
    logic              w_gap_ok;
    logic              w_tail_ok;
    logic [SIZE_W-1:0] w_next_pos;
    logic [CNT_W-1:0]  w_idx_inc;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_fire   = i_req.valid && (r_state == S_IDLE);

    assign w_zone = zone_bytes(r_zone_req);
    assign w_free = (w_zone > r_used) ? (w_zone - r_used) : '0;

    assign w_s        = {1'b0, r_rd_data.start};
    assign w_gap_ok   = (w_s >= r_pos) && ((w_s - r_pos) >= r_size);
    assign w_tail_ok  = (r_pos <= w_zone) && ((w_zone - r_pos) >= r_size);
    assign w_next_pos = w_s + r_rd_data.size;
    assign w_idx_inc  = r_idx + CNT_W'(1);

    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.alloc_offset = r_out_offset;
    assign o_res.found_size   = r_out_found;
    assign o_res.avail_bytes  = r_out_free;
    assign o_res.block_count  = r_out_count;

    always_comb begin
        n_state   = r_state;
        n_live    = r_live;
        n_used    = r_used;
        n_op      = r_op;
        n_size    = r_size;
        n_off     = r_off;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_status  = r_status;
        n_placed  = r_placed;
        n_found   = r_found;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_op     = i_req.op;
                    n_size   = i_req.req_size;
                    n_off    = i_req.offset;
                    n_idx    = '0;
                    n_pos    = '0;
                    n_placed = '0;
                    n_found  = '0;
                    n_status = STAT_BADARG;
                    n_state  = S_EMIT;
                    if (i_req.op == OP_ALLOC) begin
                        priority if (i_req.req_size == '0) begin
                            n_status = STAT_BADARG;
                        end else if (r_live >= CNT_W'(MAX_BLOCKS)) begin
                            n_status = STAT_FULL;
                        end else if (i_req.req_size > w_free) begin
                            n_status = STAT_NOSPACE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_req.op == OP_FREE || i_req.op == OP_QUERY) begin
                        if ({1'b0, i_req.offset} < w_zone) begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                w_rd_addr = w_idx_inc[IDX_W-1:0];
                if (r_op == OP_ALLOC) begin
                    if (r_idx == r_live || w_gap_ok) begin
                        if (r_idx != r_live || w_tail_ok) begin
                            // open a hole at r_idx, moving the upper entries up by one
                            if (r_idx == r_live) begin
                                n_state = S_PUT;
                            end else begin
                                n_cnt     = r_live;
                                w_rd_addr = IDX_W'(r_live - CNT_W'(1));
                                n_state   = S_SHIFT_UP;
                            end
                        end else begin
                            n_status = STAT_NOSPACE;
                            n_state  = S_EMIT;
                        end
                    end else begin
                        n_pos = w_next_pos;
                        n_idx = w_idx_inc;
                    end
                end else begin
                    if (r_idx == r_live) begin
                        n_status = STAT_NOTFOUND;
                        n_state  = S_EMIT;
                    end else if (r_rd_data.start == r_off) begin
                        n_status = STAT_OK;
                        if (r_op == OP_QUERY) begin
                            n_found = r_rd_data.size;
                            n_state = S_EMIT;
                        end else begin
                            n_used = (r_used >= r_rd_data.size) ? (r_used - r_rd_data.size) : '0;
                            if (w_idx_inc == r_live) begin
                                n_live  = r_live - CNT_W'(1);
                                n_state = S_EMIT;
                            end else begin
                                n_cnt     = r_idx;
                                w_rd_addr = IDX_W'(r_idx + CNT_W'(1));
                                n_state   = S_SHIFT_DN;
                            end
                        end
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end
            end

            S_SHIFT_UP: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt[IDX_W-1:0];
                w_wr_data = r_rd_data;
                if (CNT_W'(r_cnt - CNT_W'(1)) == r_idx) begin
                    n_state = S_PUT;
                end else begin
                    n_cnt     = r_cnt - CNT_W'(1);
                    w_rd_addr = IDX_W'(r_cnt - CNT_W'(2));
                end
            end

            S_PUT: begin
                w_wr_en         = 1'b1;
                w_wr_addr       = r_idx[IDX_W-1:0];
                w_wr_data.start = r_pos[OFF_W-1:0];
                w_wr_data.size  = r_size;
                n_live          = r_live + CNT_W'(1);
                n_used          = r_used + r_size;
                n_status        = STAT_OK;
                n_placed        = r_pos[OFF_W-1:0];
                n_state         = S_EMIT;
            end

            S_SHIFT_DN: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt[IDX_W-1:0];
                w_wr_data = r_rd_data;
                if (CNT_W'(r_cnt + CNT_W'(2)) == r_live) begin
                    n_live  = r_live - CNT_W'(1);
                    n_state = S_EMIT;
                end else begin
                    n_cnt     = r_cnt + CNT_W'(1);
                    w_rd_addr = IDX_W'(r_cnt + CNT_W'(2));
                end
            end

            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_req  <= RESET_ZONE_REQ;
            r_live      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_zone_req <= i_cfg.data;
            end
            r_live <= n_live;
            r_used <= n_used;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_size   <= n_size;
        r_off    <= n_off;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_placed <= n_placed;
        r_found  <= n_found;
        if (w_emit) begin
            r_out_status <= STAT_W'(r_status);
            r_out_offset <= r_placed;
            r_out_found  <= r_found;
            r_out_free   <= w_free;
            r_out_count  <= r_live;
        end
    end

    // entry table: the read is registered, so the address is issued in the cycle before the data is used
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ZONE_LIMIT)
        else $error("used bytes above offset space");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_state != S_IDLE)
        else $error("sequencer idle right after a transfer");

    a_insert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_UP || r_state == S_PUT) |-> r_live < CNT_W'(MAX_BLOCKS))
        else $error("insert into a full table");

    a_put_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUT |=> r_live == CNT_W'($past(r_live) + CNT_W'(1)))
        else $error("insert did not bump the block count");
`endif

endmodule
